// ===== src/bmse_pkg.sv =====
// Package: shared types, constants and the per-cell charge table of the SoC estimator.
package bmse_pkg;

   localparam int TABLE_POINTS = 17;
   localparam int IDX_W        = 5;
   localparam int GAIN_RESET   = 13204;
   localparam int ALPHA_RESET  = 6554;

   // Register indexes of the configuration channel.
   localparam logic REG_ADC_GAIN     = 1'b0;
   localparam logic REG_FILTER_ALPHA = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_FILTER,
      ST_CLASSIFY,
      ST_RANGE,
      ST_SEARCH,
      ST_MULT,
      ST_DIVIDE
   } st_type;

   // Per-cell voltage in mV, falling.
   function automatic logic [12:0] cell_mv(input logic [IDX_W-1:0] idx);
      logic [12:0] v;
      unique case (idx)
         5'd0:  v = 13'd4200;
         5'd1:  v = 13'd4150;
         5'd2:  v = 13'd4110;
         5'd3:  v = 13'd4080;
         5'd4:  v = 13'd4020;
         5'd5:  v = 13'd3980;
         5'd6:  v = 13'd3950;
         5'd7:  v = 13'd3910;
         5'd8:  v = 13'd3870;
         5'd9:  v = 13'd3850;
         5'd10: v = 13'd3840;
         5'd11: v = 13'd3820;
         5'd12: v = 13'd3800;
         5'd13: v = 13'd3780;
         5'd14: v = 13'd3750;
         5'd15: v = 13'd3730;
         default: v = 13'd3700;
      endcase
      return v;
   endfunction

   // Charge percentage at each table point.
   function automatic logic [6:0] cell_pct(input logic [IDX_W-1:0] idx);
      logic [6:0] p;
      unique case (idx)
         5'd0:  p = 7'd100;
         5'd1:  p = 7'd95;
         5'd2:  p = 7'd90;
         5'd3:  p = 7'd85;
         5'd4:  p = 7'd80;
         5'd5:  p = 7'd75;
         5'd6:  p = 7'd70;
         5'd7:  p = 7'd60;
         5'd8:  p = 7'd50;
         5'd9:  p = 7'd45;
         5'd10: p = 7'd40;
         5'd11: p = 7'd30;
         5'd12: p = 7'd20;
         5'd13: p = 7'd15;
         5'd14: p = 7'd10;
         5'd15: p = 7'd5;
         default: p = 7'd0;
      endcase
      return p;
   endfunction

   // Pack-level threshold: cells times a per-cell mV value (cells is 1 to 3).
   function automatic logic [14:0] cell_scale(input logic [1:0] cells, input logic [12:0] v);
      logic [14:0] r;
      unique case (cells)
         2'd3:    r = {2'b00, v} + {1'b0, v, 1'b0};
         2'd2:    r = {1'b0, v, 1'b0};
         default: r = {2'b00, v};
      endcase
      return r;
   endfunction

endpackage

// ===== src/bmse_req_if.sv =====
// Interfaces: request, response and configuration channels of the SoC estimator.
interface bmse_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink (input valid, input adc_sample, output ready);
endinterface

interface bmse_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] battery_mv;
   logic [1:0]  cells_found;
   logic [6:0]  charge_percent;
   modport source (output valid, output battery_mv, output cells_found,
                   output charge_percent, input ready);
   modport sink (input valid, input battery_mv, input cells_found,
                 input charge_percent, output ready);
endinterface

interface bmse_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [16:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/battery_monitor_soc_estimator_top.sv =====
// Top level: battery pack voltage filter, cell count detection and charge estimate.
// Steps from acceptance to response valid: scaling, filter (skipped for the first sample),
// classification, range check, table search and interpolation (multiply, then divide);
// a clamped or undetected result skips search and interpolation and goes to the hand-off.
// The next request waits until the last result can enter the response register.
// Reset (synchronous, active high) restores the register defaults and clears the filter.
module battery_monitor_soc_estimator_top (
   input  logic              clock,
   input  logic              reset,
   bmse_req_if.sink          req_bus,
   bmse_rsp_if.source        rsp_bus,
   bmse_csr_if.sink          csr_bus
);

   bmse_pkg::st_type state_ff, state_in;

   logic [15:0] gain_ff;
   logic [16:0] alpha_ff;

   logic [4:0]  cnt_ff;
   logic [11:0] samp_sh_ff;
   logic [27:0] gain_sh_ff;
   logic [16:0] a_sh_ff;
   logic signed [49:0] acc_ff;
   logic signed [49:0] diff_sh_ff;
   logic [31:0] f_ff;
   logic        started_ff;
   logic [1:0]  cells_ff;
   logic [15:0] bmv_ff;
   logic [6:0]  pct_ff;
   logic [3:0]  idx_ff;
   logic [3:0]  dp_ff;
   logic [6:0]  plo_ff;
   logic [29:0] rem_sh_ff;
   logic [29:0] num_ff;
   logic [25:0] den_ff;
   logic [30:0] nrem_ff;
   logic [29:0] dsh_ff;
   logic [3:0]  q_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_mv_ff;
   logic [1:0]  rsp_cells_ff;
   logic [6:0]  rsp_pct_ff;
   logic        finish;

   // Configuration is always taken; writes to an unknown index cannot occur with a
   // one-bit index, both codes are real registers.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 16'(bmse_pkg::GAIN_RESET);
         alpha_ff <= 17'(bmse_pkg::ALPHA_RESET);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            bmse_pkg::REG_ADC_GAIN:     gain_ff  <= csr_bus.data[15:0];
            bmse_pkg::REG_FILTER_ALPHA: alpha_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // Combinational views of the current search segment.
   logic [14:0] hi_pack, lo_pack, top_pack, bot_pack;
   logic [31:0] hi_q, lo_q, top_q, bot_q;
   logic [4:0]  idx_next;
   logic        seg_hit;
   logic [28:0] scale_rnd;
   logic signed [49:0] filt_rnd;
   logic [16:0] bmv_rnd;

   assign idx_next = {1'b0, idx_ff} + 5'd1;
   assign hi_pack  = bmse_pkg::cell_scale(cells_ff, bmse_pkg::cell_mv({1'b0, idx_ff}));
   assign lo_pack  = bmse_pkg::cell_scale(cells_ff, bmse_pkg::cell_mv(idx_next));
   assign top_pack = bmse_pkg::cell_scale(cells_ff, bmse_pkg::cell_mv(5'd0));
   assign bot_pack = bmse_pkg::cell_scale(cells_ff,
                        bmse_pkg::cell_mv(5'(bmse_pkg::TABLE_POINTS - 1)));
   assign hi_q     = {1'b0, hi_pack, 16'h0000};
   assign lo_q     = {1'b0, lo_pack, 16'h0000};
   assign top_q    = {1'b0, top_pack, 16'h0000};
   assign bot_q    = {1'b0, bot_pack, 16'h0000};
   assign seg_hit  = (f_ff <= hi_q) && (f_ff >= lo_q);
   assign scale_rnd = {1'b0, acc_ff[27:0]} + 29'd2048;
   assign filt_rnd  = acc_ff + 50'sd32768;
   assign bmv_rnd   = 17'({1'b0, f_ff} + 33'd32768 >> 16);

   // Next state and handshake outputs.
   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      finish        = 1'b0;
      unique case (state_ff)
         bmse_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) state_in = bmse_pkg::ST_SCALE;
         end
         bmse_pkg::ST_SCALE: begin
            if (cnt_ff == 5'd12) state_in = started_ff ? bmse_pkg::ST_FILTER
                                                       : bmse_pkg::ST_CLASSIFY;
         end
         bmse_pkg::ST_FILTER: begin
            if (cnt_ff == 5'd17) state_in = bmse_pkg::ST_CLASSIFY;
         end
         bmse_pkg::ST_CLASSIFY: state_in = bmse_pkg::ST_RANGE;
         bmse_pkg::ST_RANGE: begin
            if (cells_ff == 2'd0 || f_ff >= top_q || f_ff <= bot_q) begin
               state_in = bmse_pkg::ST_DIVIDE;
               finish   = 1'b1;
            end else begin
               state_in = bmse_pkg::ST_SEARCH;
            end
         end
         bmse_pkg::ST_SEARCH: if (seg_hit) state_in = bmse_pkg::ST_MULT;
         bmse_pkg::ST_MULT:   if (cnt_ff == 5'd4) state_in = bmse_pkg::ST_DIVIDE;
         bmse_pkg::ST_DIVIDE: begin
            // The divide state doubles as the hand-off slot to the response register.
            if (cnt_ff >= 5'd4 && (!rsp_valid_ff || rsp_bus.ready)) begin
               state_in = bmse_pkg::ST_IDLE;
            end
         end
         default: state_in = bmse_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bmse_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // Datapath sequencing.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         cells_ff   <= 2'd0;
         f_ff       <= 32'd0;
         cnt_ff     <= 5'd0;
      end else begin
         unique case (state_ff)
            bmse_pkg::ST_IDLE: begin
               samp_sh_ff <= req_bus.adc_sample;
               gain_sh_ff <= {12'd0, gain_ff};
               acc_ff     <= '0;
               cnt_ff     <= 5'd0;
            end
            bmse_pkg::ST_SCALE: begin
               if (cnt_ff == 5'd12) begin
                  // The scaled sample never exceeds 16 bits for a 12-bit sample and
                  // a 16-bit gain, so no saturation is needed here.
                  cnt_ff <= 5'd0;
                  if (!started_ff) begin
                     f_ff       <= {scale_rnd[27:12], 16'h0000};
                     started_ff <= 1'b1;
                  end else begin
                     acc_ff     <= signed'({2'b00, f_ff, 16'h0000});
                     diff_sh_ff <= 50'(signed'({1'b0, scale_rnd[27:12], 16'h0000})
                                     - signed'({1'b0, f_ff}));
                     a_sh_ff    <= alpha_ff[16] ? 17'h10000 : alpha_ff;
                  end
               end else begin
                  if (samp_sh_ff[0]) acc_ff <= acc_ff + signed'({22'd0, gain_sh_ff});
                  samp_sh_ff <= samp_sh_ff >> 1;
                  gain_sh_ff <= gain_sh_ff << 1;
                  cnt_ff     <= cnt_ff + 5'd1;
               end
            end
            bmse_pkg::ST_FILTER: begin
               // Blend: f*65536 + alpha*(sample - f), one alpha bit per cycle.
               if (cnt_ff == 5'd17) begin
                  f_ff   <= filt_rnd[47:16];
                  cnt_ff <= 5'd0;
               end else begin
                  if (a_sh_ff[0]) acc_ff <= acc_ff + diff_sh_ff;
                  a_sh_ff    <= a_sh_ff >> 1;
                  diff_sh_ff <= diff_sh_ff <<< 1;
                  cnt_ff     <= cnt_ff + 5'd1;
               end
            end
            bmse_pkg::ST_CLASSIFY: begin
               if (cells_ff == 2'd0 && f_ff >= 32'(4000 << 16)) begin
                  if (f_ff >= 32'(9000 << 16))      cells_ff <= 2'd3;
                  else if (f_ff >= 32'(6000 << 16)) cells_ff <= 2'd2;
                  else                              cells_ff <= 2'd1;
               end
               bmv_ff <= bmv_rnd[16] ? 16'hFFFF : bmv_rnd[15:0];
               idx_ff <= 4'd0;
            end
            bmse_pkg::ST_RANGE: begin
               cnt_ff <= finish ? 5'd4 : 5'd0;
               if (cells_ff != 2'd0 && f_ff >= top_q) pct_ff <= 7'd100;
               else                                   pct_ff <= 7'd0;
            end
            bmse_pkg::ST_SEARCH: begin
               if (seg_hit) begin
                  dp_ff     <= 4'(bmse_pkg::cell_pct({1'b0, idx_ff})
                                  - bmse_pkg::cell_pct(idx_next));
                  plo_ff    <= bmse_pkg::cell_pct(idx_next);
                  rem_sh_ff <= 30'(f_ff - lo_q);
                  den_ff    <= 26'(hi_q - lo_q);
                  num_ff    <= '0;
                  cnt_ff    <= 5'd0;
               end else begin
                  idx_ff <= idx_next[3:0];
               end
            end
            bmse_pkg::ST_MULT: begin
               if (cnt_ff == 5'd4) begin
                  nrem_ff <= {num_ff, 1'b0} + {5'd0, den_ff};
                  dsh_ff  <= {3'd0, den_ff, 1'b0} << 3;
                  q_ff    <= 4'd0;
                  cnt_ff  <= 5'd0;
               end else begin
                  if (dp_ff[0]) num_ff <= num_ff + rem_sh_ff;
                  dp_ff     <= dp_ff >> 1;
                  rem_sh_ff <= rem_sh_ff << 1;
                  cnt_ff    <= cnt_ff + 5'd1;
               end
            end
            bmse_pkg::ST_DIVIDE: begin
               if (cnt_ff < 5'd4) begin
                  // Restoring division, one quotient bit per cycle.
                  if (nrem_ff >= {1'b0, dsh_ff}) begin
                     nrem_ff <= nrem_ff - {1'b0, dsh_ff};
                     q_ff    <= {q_ff[2:0], 1'b1};
                  end else begin
                     q_ff    <= {q_ff[2:0], 1'b0};
                  end
                  dsh_ff <= dsh_ff >> 1;
                  cnt_ff <= cnt_ff + 5'd1;
               end else if (cnt_ff == 5'd4 && pct_ff == 7'd0 && plo_ff != 7'd127) begin
                  cnt_ff <= 5'd4;
               end
            end
            default: ;
         endcase
      end
   end

   // The interpolated percentage, known only on the path that went through the search.
   logic        interp_ff;
   logic [7:0]  pct_sum;
   assign pct_sum = {1'b0, plo_ff} + {4'd0, q_ff};

   always_ff @(posedge clock) begin
      if (reset)                               interp_ff <= 1'b0;
      else if (state_ff == bmse_pkg::ST_RANGE) interp_ff <= !finish;
   end

   // Response register: holds a finished result while the next request is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == bmse_pkg::ST_DIVIDE && state_in == bmse_pkg::ST_IDLE) begin
            rsp_valid_ff <= 1'b1;
            rsp_mv_ff    <= bmv_ff;
            rsp_cells_ff <= cells_ff;
            if (interp_ff) rsp_pct_ff <= pct_sum > 8'd100 ? 7'd100 : pct_sum[6:0];
            else           rsp_pct_ff <= pct_ff;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.battery_mv     = rsp_mv_ff;
   assign rsp_bus.cells_found    = rsp_cells_ff;
   assign rsp_bus.charge_percent = rsp_pct_ff;

   // A request is taken only from idle and always starts the scaling step.
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> state_ff == bmse_pkg::ST_SCALE)
      else $error("request accepted without starting the scale step");

   // Once detected, the cell count never changes.
   a_cells_latched: assert property (@(posedge clock) disable iff (reset)
      (cells_ff != 2'd0) |=> cells_ff == $past(cells_ff))
      else $error("latched cell count changed");

   // The reported charge stays within 0 to 100 percent.
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pct_ff <= 7'd100)
      else $error("charge percent above 100");

   // Before detection the reported charge is zero.
   a_pct_undetected: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cells_ff == 2'd0) |-> rsp_pct_ff == 7'd0)
      else $error("nonzero charge without a cell count");

endmodule

// ===== sim/bmse_tb_if.sv =====
// Testbench-side helper: the package and interfaces come from the RTL sources.
package bmse_tb_pkg;

   // One result of the estimator as the checker expects it.
   typedef struct packed {
      logic [15:0] battery_mv;
      logic [1:0]  cells_found;
      logic [6:0]  charge_percent;
   } soc_result_type;
endpackage

// ===== sim/battery_monitor_soc_estimator_checker.sv =====
// Checker: watches the estimator channels, predicts each result and compares it.
module battery_monitor_soc_estimator_checker (
   input  logic  clock,
   input  logic  reset,
   bmse_req_if   req_bus,
   bmse_rsp_if   rsp_bus,
   bmse_csr_if   csr_bus,
   output int    fail_count,
   output int    pending_count,
   output int    result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [15:0] gain_q;
   logic [16:0] alpha_q;
   logic [31:0] voltage_q16;
   logic        filter_live;
   logic [1:0]  cells_q;
   bmse_tb_pkg::soc_result_type expected_q[$];

   function automatic logic [6:0] table_percent(input logic [63:0] f,
                                                input logic [1:0] cells);
      logic [63:0] hi, lo, num, den, pct;
      if (f >= 64'(cells) * (64'(bmse_pkg::cell_mv(5'd0)) << 16)) return 7'd100;
      if (f <= 64'(cells) * (64'(bmse_pkg::cell_mv(5'd16)) << 16)) return 7'd0;
      for (int i = 0; i < bmse_pkg::TABLE_POINTS - 1; i++) begin
         hi = 64'(cells) * (64'(bmse_pkg::cell_mv(5'(i))) << 16);
         lo = 64'(cells) * (64'(bmse_pkg::cell_mv(5'(i + 1))) << 16);
         if (f <= hi && f >= lo && hi > lo) begin
            num = (f - lo) * 64'(bmse_pkg::cell_pct(5'(i)) - bmse_pkg::cell_pct(5'(i + 1)));
            den = hi - lo;
            pct = 64'(bmse_pkg::cell_pct(5'(i + 1))) + (2 * num + den) / (2 * den);
            return pct > 100 ? 7'd100 : pct[6:0];
         end
      end
      return 7'd0;
   endfunction

   function automatic bmse_tb_pkg::soc_result_type estimate_charge(input logic [11:0] sample);
      logic [63:0] mv, a, f;
      bmse_tb_pkg::soc_result_type r;
      mv = (64'(sample) * 64'(gain_q) + 2048) >> 12;
      if (mv > 65535) mv = 65535;
      a = alpha_q > 17'd65536 ? 64'd65536 : 64'(alpha_q);
      if (!filter_live) begin
         voltage_q16 = 32'(mv << 16);
         filter_live = 1'b1;
      end else begin
         f = ((65536 - a) * 64'(voltage_q16) + a * (mv << 16) + 32768) >> 16;
         voltage_q16 = f[31:0];
      end
      f = 64'(voltage_q16);
      if (cells_q == 2'd0 && f >= (64'd4000 << 16)) begin
         if (f >= (64'd9000 << 16)) cells_q = 2'd3;
         else if (f >= (64'd6000 << 16)) cells_q = 2'd2;
         else cells_q = 2'd1;
      end
      mv = (f + 32768) >> 16;
      if (mv > 65535) mv = 65535;
      r.battery_mv = mv[15:0];
      r.cells_found = cells_q;
      r.charge_percent = cells_q == 2'd0 ? 7'd0 : table_percent(f, cells_q);
      return r;
   endfunction

   always @(posedge clock) begin
      bmse_tb_pkg::soc_result_type e;
      if (reset) begin
         gain_q <= 16'(bmse_pkg::GAIN_RESET);
         alpha_q <= 17'(bmse_pkg::ALPHA_RESET);
         voltage_q16 = '0;
         filter_live = 1'b0;
         cells_q = '0;
         expected_q.delete();
         fail_count <= 0;
         result_count <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            if (csr_bus.index == bmse_pkg::REG_ADC_GAIN) gain_q <= csr_bus.data[15:0];
            else alpha_q <= csr_bus.data;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count <= result_count + 1;
            if (expected_q.size() == 0) begin
               $error("result with no transaction outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (rsp_bus.battery_mv !== e.battery_mv ||
                   rsp_bus.cells_found !== e.cells_found ||
                   rsp_bus.charge_percent !== e.charge_percent)
                  fail_count <= fail_count + 1;
               if (rsp_bus.battery_mv !== e.battery_mv)
                  $error("battery_mv expected %0d actual %0d", e.battery_mv,
                         rsp_bus.battery_mv);
               if (rsp_bus.cells_found !== e.cells_found)
                  $error("cells_found expected %0d actual %0d", e.cells_found,
                         rsp_bus.cells_found);
               if (rsp_bus.charge_percent !== e.charge_percent)
                  $error("charge_percent expected %0d actual %0d", e.charge_percent,
                         rsp_bus.charge_percent);
            end
         end
         if (req_bus.valid && req_bus.ready)
            expected_q.push_back(estimate_charge(req_bus.adc_sample));
      end
      pending_count <= expected_q.size();
   end
endmodule

// ===== sim/battery_monitor_soc_estimator_top_tb.sv =====
// Testbench top: drives samples and register writes, then reports the verdict.
module battery_monitor_soc_estimator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1250;
   localparam int STALL_LIMIT  = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, result_count;
   int   idle_cycles = 0;
   bit   calm_phase = 1'b0;     // no random idling near the end of the run
   bit   long_hold = 1'b0;      // receiver is holding off on purpose
   int   samples_sent = 0;
   int   settings_used = 0;

   bmse_req_if req_bus();
   bmse_rsp_if rsp_bus();
   bmse_csr_if csr_bus();

   battery_monitor_soc_estimator_top dut (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus)
   );

   battery_monitor_soc_estimator_checker checker_i (
      .clock(clock), .reset(reset),
      .req_bus(req_bus), .rsp_bus(rsp_bus), .csr_bus(csr_bus),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.adc_sample = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = bmse_pkg::REG_ADC_GAIN;
      csr_bus.data = '0;
   end

   // The watchdog counts cycles without any transaction on any channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // The receiver stalls in random bursts, or for one long stretch on request,
   // and is always ready once the run reaches its calm final part.
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            for (n = 0; n < 400; n++) @(negedge clock);
            long_hold = 1'b0;
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(negedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(negedge clock);
         end
      end
   end

   // Offers one sample and waits for its handshake. Random gaps come first
   // so that the idle stretches land on every phase of the block's sequence.
   task automatic send_sample(input logic [11:0] sample);
      int gap;
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.adc_sample <= sample;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
      samples_sent++;
   endtask

   // Lowers valid and waits until every outstanding result has been returned.
   task automatic drain_results;
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      // Let the block settle back to idle before the next register write.
      repeat (80) @(negedge clock);
   endtask

   // A register write; only issued while the block is drained.
   task automatic write_register(input logic reg_index, input logic [16:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= reg_index;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(negedge clock);
      settings_used++;
   endtask

   // Random sample biased toward the ranges that reach the cell thresholds
   // and the table segments under the current gain.
   function automatic logic [11:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return 12'hFFF;
         2, 3: return 12'($urandom_range(0, 4095));
         default: return 12'($urandom_range(1100, 3200));
      endcase
   endfunction

   initial begin
      int per_phase;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset settings: the filter loads from the first
      // sample, then the field extremes move it gently under the default alpha.
      send_sample(12'd1300);
      send_sample(12'd0);
      send_sample(12'hFFF);
      send_sample(12'hAAA);
      send_sample(12'h555);
      drain_results();

      // No filtering: each result follows its own sample. The samples walk
      // through the single-cell table, from below the bottom point to the top.
      write_register(bmse_pkg::REG_FILTER_ALPHA, 17'd65536);
      send_sample(12'd1241);   // just at 4.0 V; one cell is already latched
      send_sample(12'd1100);   // below the bottom table point
      send_sample(12'd1148);
      send_sample(12'd1163);
      send_sample(12'd1185);
      send_sample(12'd1210);
      send_sample(12'd1245);
      send_sample(12'd1280);
      send_sample(12'd1303);   // at the top table point
      send_sample(12'd1500);   // above it
      drain_results();

      // Alpha above one behaves as one; alpha zero holds the filter; the
      // largest gain gives the highest pack voltage, still without saturation.
      write_register(bmse_pkg::REG_FILTER_ALPHA, 17'h1FFFF);
      write_register(bmse_pkg::REG_ADC_GAIN, 16'hFFFF);
      send_sample(12'hFFF);
      send_sample(12'd7);
      drain_results();
      write_register(bmse_pkg::REG_FILTER_ALPHA, 17'd0);
      send_sample(12'd0);
      send_sample(12'hFFF);
      drain_results();
      write_register(bmse_pkg::REG_ADC_GAIN, 16'd0);
      send_sample(12'hFFF);
      drain_results();

      // Random phases: the bench does not reset the detection state between them,
      // so cell count stays latched; the settings still vary the arithmetic.
      per_phase = RANDOM_ITEMS / 5;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin write_register(bmse_pkg::REG_ADC_GAIN, 16'(bmse_pkg::GAIN_RESET));
                  write_register(bmse_pkg::REG_FILTER_ALPHA,
                                 17'(bmse_pkg::ALPHA_RESET)); end
            1: begin write_register(bmse_pkg::REG_ADC_GAIN, 16'($urandom_range(0, 65535)));
                  write_register(bmse_pkg::REG_FILTER_ALPHA,
                                 17'($urandom_range(0, 131071))); end
            2: begin write_register(bmse_pkg::REG_ADC_GAIN, 16'd13204);
                  write_register(bmse_pkg::REG_FILTER_ALPHA, 17'd65536); end
            3: begin write_register(bmse_pkg::REG_ADC_GAIN,
                                    16'($urandom_range(9000, 20000)));
                  write_register(bmse_pkg::REG_FILTER_ALPHA,
                                 17'($urandom_range(1, 65535))); end
            default: begin write_register(bmse_pkg::REG_ADC_GAIN, 16'd13204);
                  write_register(bmse_pkg::REG_FILTER_ALPHA, 17'd32768); end
         endcase
         if (phase == 4) calm_phase = 1'b1;
         for (int k = 0; k < per_phase; k++) begin
            // Midway through the first phase the receiver holds off while
            // samples keep coming, so the block backs up and stalls its input.
            if (phase == 0 && k == per_phase / 2) long_hold = 1'b1;
            send_sample(pick_sample());
            // Once, the sender stops until every result is back.
            if (phase == 1 && k == per_phase / 2) begin
               req_bus.valid <= 1'b0;
               @(negedge clock);
               while (pending_count != 0) @(negedge clock);
            end
         end
         drain_results();
      end

      $display("Covered %0d samples and %0d results over %0d register writes,",
               samples_sent, result_count, settings_used);
      $display("including gain and alpha extremes and long receiver stalls.");
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

// ===== battery_monitor_soc_estimator_top.f =====
src/bmse_pkg.sv
src/bmse_req_if.sv
src/battery_monitor_soc_estimator_top.sv
sim/bmse_tb_if.sv
sim/battery_monitor_soc_estimator_checker.sv
sim/battery_monitor_soc_estimator_top_tb.sv
